[rtl/dcpl_pkg.sv]
// Shared types, request codes and constants for the critical path length block.
package dcpl_pkg;

  localparam int DEF_MAX_NODES     = 128;
  localparam int DEF_DURATION_BITS = 16;

  localparam int FUNC_W     = 2;
  localparam int NODE_W     = 8;
  localparam int DUR_W      = 16;
  localparam int FINISH_W   = 23;
  localparam logic [FINISH_W-1:0] FINISH_MAX = {FINISH_W{1'b1}};

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD = 2'd0,
    FUNC_EDGE = 2'd1,
    FUNC_RUN  = 2'd2,
    FUNC_NONE = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EDGE,
    ST_SEED,
    ST_SEED_CHK,
    ST_POP,
    ST_CUR,
    ST_ROW,
    ST_SCAN,
    ST_UPD,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_len;
    logic edge_rd;
    logic edge_wr;
    logic run_start;
    logic seed_chk;
    logic pop;
    logic cur_rd;
    logic row_lat;
    logic scan_rd;
    logic scan_skip;
    logic upd;
    logic out_load;
    logic clr;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    func_t func;
    logic  node_ok;
    logic  edge_ok;
    logic  head_lt_tail;
    logic  idx_at_n;
    logic  idx_at_end;
    logic  idx_last;
    logic  row_bit;
    logic  out_free;
  } sts_t;

endpackage

[rtl/dag_critical_path_length_top.sv]
// Top level of the task graph critical path length block.
//
// Requests load a project one at a time: a task request (func 0) stores its duration and an
// edge request (func 1) reads the successor row and the predecessor count, then writes them.
// A run request (func 2) walks the graph in topological order from the tasks with no
// predecessor and returns the longest weighted path as project_time. The run first checks
// each task index below the node count, then for each task taken from the ready queue reads
// its finish time and successor row, and one shared update step scans that row bit by bit.
// After each run, and after reset, a clearing pass over all MAX_NODES entries zeroes the
// predecessor counts, finish times and successor rows; no request is taken meanwhile.
// Task durations are kept across runs. A finished result waits in its own register, so
// new requests are taken while it is stalled.
module dag_critical_path_length_top import dcpl_pkg::*; #(
  parameter int MAX_NODES     = DEF_MAX_NODES,
  parameter int DURATION_BITS = DEF_DURATION_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [FUNC_W-1:0]   func,
  input  logic [NODE_W-1:0]   node,
  input  logic [DUR_W-1:0]    duration,
  input  logic [NODE_W-1:0]   successor,
  input  logic [NODE_W-1:0]   node_count,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [FINISH_W-1:0] project_time
);

  cmd_t cmd;
  sts_t sts;

  dcpl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  dcpl_dp #(
    .MAX_NODES     (MAX_NODES),
    .DURATION_BITS (DURATION_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .func         (func),
    .node         (node),
    .duration     (duration),
    .successor    (successor),
    .node_count   (node_count),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .project_time (project_time),
    .cmd          (cmd),
    .sts          (sts)
  );

  // A result is never loaded over one that is still waiting.
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded while previous result still stalled");

  // An edge write always follows its own read of row and count.
  a_edge_seq: assert property (@(posedge clk) disable iff (rst)
    cmd.edge_wr |-> $past(cmd.edge_rd))
    else $error("edge write without preceding read");

  // A successor update always uses data read in the cycle before.
  a_upd_seq: assert property (@(posedge clk) disable iff (rst)
    cmd.upd |-> $past(cmd.scan_rd))
    else $error("successor update without preceding read");

  // A new result appears only as the end of a run.
  a_out_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("result appeared without a finished run");

endmodule

[rtl/dcpl_ctrl.sv]
// Controller state machine that sequences loading, the topological walk and clearing.
module dcpl_ctrl import dcpl_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.idx_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          unique case (sts.func)
            FUNC_LOAD: begin
              cmd.load_len = sts.node_ok;
            end
            FUNC_EDGE: begin
              if (sts.edge_ok) begin
                cmd.edge_rd = 1'b1;
                state_next  = ST_EDGE;
              end
            end
            FUNC_RUN: begin
              cmd.run_start = 1'b1;
              state_next    = ST_SEED;
            end
            default: begin
            end
          endcase
        end
      end
      ST_EDGE: begin
        cmd.edge_wr = 1'b1;
        state_next  = ST_IDLE;
      end
      ST_SEED: begin
        if (sts.idx_at_n) begin
          state_next = ST_POP;
        end else begin
          state_next = ST_SEED_CHK;
        end
      end
      ST_SEED_CHK: begin
        cmd.seed_chk = 1'b1;
        state_next   = ST_SEED;
      end
      ST_POP: begin
        if (sts.head_lt_tail) begin
          cmd.pop    = 1'b1;
          state_next = ST_CUR;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_CUR: begin
        cmd.cur_rd = 1'b1;
        state_next = ST_ROW;
      end
      ST_ROW: begin
        cmd.row_lat = 1'b1;
        state_next  = ST_SCAN;
      end
      ST_SCAN: begin
        priority if (sts.idx_at_end) begin
          state_next = ST_POP;
        end else if (sts.row_bit) begin
          cmd.scan_rd = 1'b1;
          state_next  = ST_UPD;
        end else begin
          cmd.scan_skip = 1'b1;
        end
      end
      ST_UPD: begin
        cmd.upd    = 1'b1;
        state_next = ST_SCAN;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_CLEAR;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

[rtl/dcpl_dp.sv]
// Datapath with the task, predecessor, finish, successor and queue stores.
module dcpl_dp import dcpl_pkg::*; #(
  parameter int MAX_NODES     = DEF_MAX_NODES,
  parameter int DURATION_BITS = DEF_DURATION_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [FUNC_W-1:0]   func,
  input  logic [NODE_W-1:0]   node,
  input  logic [DUR_W-1:0]    duration,
  input  logic [NODE_W-1:0]   successor,
  input  logic [NODE_W-1:0]   node_count,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [FINISH_W-1:0] project_time,
  input  cmd_t                cmd,
  output sts_t                sts
);

  localparam int IDX_W = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam int SUM_W = ((DURATION_BITS > FINISH_W) ? DURATION_BITS : FINISH_W) + 1;

  // Stores.
  logic [DURATION_BITS-1:0] len_mem  [MAX_NODES];
  logic [CNT_W-1:0]         pred_mem [MAX_NODES];
  logic [FINISH_W-1:0]      fin_mem  [MAX_NODES];
  logic [MAX_NODES-1:0]     row_mem  [MAX_NODES];
  logic [IDX_W-1:0]         queue_mem[MAX_NODES];

  logic [DURATION_BITS-1:0] len_rd;
  logic [CNT_W-1:0]         pred_rd;
  logic [FINISH_W-1:0]      fin_rd;
  logic [MAX_NODES-1:0]     row_rd;
  logic [IDX_W-1:0]         q_rd;

  // Counters and working registers.
  logic [CNT_W-1:0]     idx;
  logic [CNT_W-1:0]     head;
  logic [CNT_W-1:0]     tail;
  logic [CNT_W-1:0]     run_n;
  logic [FINISH_W-1:0]  best;
  logic [FINISH_W-1:0]  cur_fin;
  logic [MAX_NODES-1:0] row_reg;
  logic [IDX_W-1:0]     e_node;
  logic [IDX_W-1:0]     e_succ;

  logic [IDX_W-1:0]     idx_slot;
  logic [IDX_W-1:0]     node_slot;
  logic [IDX_W-1:0]     succ_slot;
  logic [NODE_W-1:0]    node_m1;
  logic [NODE_W-1:0]    succ_m1;
  logic                 node_in;
  logic                 succ_in;
  logic [CNT_W-1:0]     run_n_next;

  logic [IDX_W-1:0]     pred_raddr;
  logic [IDX_W-1:0]     row_raddr;
  logic [IDX_W-1:0]     fin_raddr;
  logic                 pred_we;
  logic [IDX_W-1:0]     pred_waddr;
  logic [CNT_W-1:0]     pred_wdata;
  logic                 fin_we;
  logic [FINISH_W-1:0]  fin_wdata;
  logic                 row_we;
  logic [IDX_W-1:0]     row_waddr;
  logic [MAX_NODES-1:0] row_wdata;
  logic [MAX_NODES-1:0] row_set;
  logic                 edge_new;
  logic                 push;
  logic [FINISH_W-1:0]  add_a;
  logic [SUM_W-1:0]     sum;
  logic [FINISH_W-1:0]  cand;

  assign idx_slot  = idx[IDX_W-1:0];
  assign node_m1   = node - NODE_W'(1);
  assign succ_m1   = successor - NODE_W'(1);
  assign node_slot = IDX_W'(node_m1);
  assign succ_slot = IDX_W'(succ_m1);
  assign node_in   = (node != '0) && (32'(node) <= 32'(MAX_NODES));
  assign succ_in   = (successor != '0) && (32'(successor) <= 32'(MAX_NODES));
  assign run_n_next = (32'(node_count) > 32'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                         : CNT_W'(node_count);

  // Saturating finish time: a seed adds nothing to its own duration.
  assign add_a = cmd.seed_chk ? '0 : cur_fin;
  assign sum   = SUM_W'(add_a) + SUM_W'(len_rd);
  assign cand  = (sum > SUM_W'(FINISH_MAX)) ? FINISH_MAX : sum[FINISH_W-1:0];

  assign edge_new = !row_rd[e_succ];

  always_comb begin
    row_set         = row_rd;
    row_set[e_succ] = 1'b1;
  end

  assign push = (tail < CNT_W'(MAX_NODES)) &&
                ((cmd.seed_chk && (pred_rd == '0)) ||
                 (cmd.upd && (pred_rd == CNT_W'(1))));

  // Read and write address selection.
  assign pred_raddr = cmd.edge_rd ? succ_slot : idx_slot;
  assign row_raddr  = cmd.edge_rd ? node_slot : q_rd;
  assign fin_raddr  = cmd.cur_rd ? q_rd : idx_slot;

  always_comb begin
    pred_we    = 1'b0;
    pred_waddr = idx_slot;
    pred_wdata = '0;
    if (cmd.edge_wr) begin
      pred_we    = edge_new;
      pred_waddr = e_succ;
      pred_wdata = pred_rd + CNT_W'(1);
    end else if (cmd.upd) begin
      pred_we    = (pred_rd != '0);
      pred_wdata = pred_rd - CNT_W'(1);
    end else if (cmd.clr) begin
      pred_we    = 1'b1;
    end
  end

  always_comb begin
    fin_we    = 1'b0;
    fin_wdata = cand;
    if (cmd.clr) begin
      fin_we    = 1'b1;
      fin_wdata = '0;
    end else if (cmd.seed_chk) begin
      fin_we    = (pred_rd == '0);
    end else if (cmd.upd) begin
      fin_we    = (fin_rd < cand);
    end
  end

  always_comb begin
    row_we    = 1'b0;
    row_waddr = idx_slot;
    row_wdata = '0;
    if (cmd.edge_wr) begin
      row_we    = edge_new;
      row_waddr = e_node;
      row_wdata = row_set;
    end else if (cmd.clr) begin
      row_we    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_len) begin
      len_mem[node_slot] <= DURATION_BITS'(duration);
    end
    len_rd <= len_mem[idx_slot];
  end

  always_ff @(posedge clk) begin
    if (pred_we) begin
      pred_mem[pred_waddr] <= pred_wdata;
    end
    pred_rd <= pred_mem[pred_raddr];
  end

  always_ff @(posedge clk) begin
    if (fin_we) begin
      fin_mem[idx_slot] <= fin_wdata;
    end
    fin_rd <= fin_mem[fin_raddr];
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_waddr] <= row_wdata;
    end
    row_rd <= row_mem[row_raddr];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_mem[tail[IDX_W-1:0]] <= idx_slot;
    end
    q_rd <= queue_mem[head[IDX_W-1:0]];
  end

  // Control counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx  <= '0;
      head <= '0;
      tail <= '0;
    end else begin
      if (cmd.run_start || cmd.row_lat || cmd.out_load) begin
        idx <= '0;
      end else if (cmd.seed_chk || cmd.scan_skip || cmd.upd || cmd.clr) begin
        idx <= idx + CNT_W'(1);
      end
      if (cmd.run_start) begin
        head <= '0;
      end else if (cmd.pop) begin
        head <= head + CNT_W'(1);
      end
      if (cmd.run_start) begin
        tail <= '0;
      end else if (push) begin
        tail <= tail + CNT_W'(1);
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (cmd.edge_rd) begin
      e_node <= node_slot;
      e_succ <= succ_slot;
    end
    if (cmd.run_start) begin
      run_n <= run_n_next;
      best  <= '0;
    end else if (cmd.row_lat && (fin_rd > best)) begin
      best <= fin_rd;
    end
    if (cmd.row_lat) begin
      row_reg <= row_rd;
      cur_fin <= fin_rd;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      project_time <= best;
    end
  end

  assign sts.func         = func_t'(func);
  assign sts.node_ok      = node_in;
  assign sts.edge_ok      = node_in && succ_in;
  assign sts.head_lt_tail = (head < tail);
  assign sts.idx_at_n     = (idx == run_n);
  assign sts.idx_at_end   = (idx == CNT_W'(MAX_NODES));
  assign sts.idx_last     = (idx == CNT_W'(MAX_NODES - 1));
  assign sts.row_bit      = row_reg[idx_slot];
  assign sts.out_free     = !out_valid || !out_stall;

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the critical path length block, with its own predictor.
module testbench import dcpl_pkg::*; ();

  localparam int MAX_N       = DEF_MAX_NODES;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int TARGET_REQS = 1350;
  localparam int TAIL_CYCLES = 300;

  typedef struct {
    func_t             f;
    logic [NODE_W-1:0] nd;
    logic [DUR_W-1:0]  du;
    logic [NODE_W-1:0] sc;
    logic [NODE_W-1:0] cnt;
  } req_t;

  typedef struct {
    req_t                r;
    bit                  typed;
    logic [FINISH_W-1:0] val;
  } dir_row_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [FUNC_W-1:0]   func;
  logic [NODE_W-1:0]   node;
  logic [DUR_W-1:0]    duration;
  logic [NODE_W-1:0]   successor;
  logic [NODE_W-1:0]   node_count;
  logic                out_valid;
  logic                out_stall;
  logic [FINISH_W-1:0] project_time;

  dag_critical_path_length_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .node         (node),
    .duration     (duration),
    .successor    (successor),
    .node_count   (node_count),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .project_time (project_time)
  );

  // Predictor copy of the task graph.
  bit [DUR_W-1:0]    task_dur  [MAX_N];
  bit [NODE_W-1:0]   pred_cnt  [MAX_N];
  bit [FINISH_W-1:0] finish_at [MAX_N];
  bit                succ_map  [MAX_N][MAX_N];

  logic [FINISH_W-1:0] exp_project_time [$];
  logic [FINISH_W-1:0] want;
  logic [FINISH_W-1:0] longest_seen;
  req_t                plan [$];
  dir_row_t            dir_rows [24];

  int err_cnt;
  int n_effective;
  int n_ignored;
  int n_runs;
  int n_results;
  int burst_left;
  int cycle_cnt;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic bit slot_ok(input logic [NODE_W-1:0] v);
    return v >= 1 && v <= MAX_N;
  endfunction

  function automatic logic [FINISH_W-1:0] sat_add(input logic [FINISH_W-1:0] a,
                                                  input logic [DUR_W-1:0] b);
    logic [FINISH_W:0] s;
    s = a + b;
    return (s > FINISH_MAX) ? FINISH_MAX : s[FINISH_W-1:0];
  endfunction

  // Kahn walk over the loaded graph; returns the longest weighted path and clears the graph.
  function automatic logic [FINISH_W-1:0] longest_path(input logic [NODE_W-1:0] count);
    int                  n;
    int                  cur;
    int                  ready [$];
    logic [FINISH_W-1:0] best;
    logic [FINISH_W-1:0] cand;
    n    = (count > MAX_N) ? MAX_N : int'(count);
    best = '0;
    for (int i = 0; i < n; i++) begin
      if (pred_cnt[i] == 0) begin
        ready.push_back(i);
        finish_at[i] = sat_add('0, task_dur[i]);
      end
    end
    while (ready.size() > 0) begin
      cur = ready.pop_front();
      for (int s = 0; s < MAX_N; s++) begin
        if (succ_map[cur][s]) begin
          cand = sat_add(finish_at[cur], task_dur[s]);
          if (finish_at[s] < cand) finish_at[s] = cand;
          if (pred_cnt[s] > 0) begin
            pred_cnt[s]--;
            if (pred_cnt[s] == 0 && ready.size() < MAX_N) ready.push_back(s);
          end
        end
      end
      if (finish_at[cur] > best) best = finish_at[cur];
    end
    for (int i = 0; i < MAX_N; i++) begin
      pred_cnt[i]  = '0;
      finish_at[i] = '0;
      for (int s = 0; s < MAX_N; s++) succ_map[i][s] = 1'b0;
    end
    return best;
  endfunction

  task automatic apply_request(input req_t r, output bit has_res,
                               output logic [FINISH_W-1:0] res);
    has_res = 1'b0;
    res     = '0;
    case (r.f)
      FUNC_LOAD: begin
        if (slot_ok(r.nd)) begin
          task_dur[r.nd-1] = r.du;
          n_effective++;
        end else begin
          n_ignored++;
        end
      end
      FUNC_EDGE: begin
        if (slot_ok(r.nd) && slot_ok(r.sc)) begin
          // A repeated edge is stored once and counted once.
          if (!succ_map[r.nd-1][r.sc-1]) begin
            succ_map[r.nd-1][r.sc-1] = 1'b1;
            pred_cnt[r.sc-1]++;
          end
          n_effective++;
        end else begin
          n_ignored++;
        end
      end
      FUNC_RUN: begin
        res     = longest_path(r.cnt);
        has_res = 1'b1;
        n_effective++;
        n_runs++;
      end
      default: n_ignored++;
    endcase
  endtask

  // Sender bursts: a random gap opens each new burst, sometimes none at all.
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      case ($urandom_range(0, 3))
        0:       gap = 0;
        1:       gap = $urandom_range(1, 3);
        2:       gap = $urandom_range(4, 12);
        default: gap = $urandom_range(1, 30);
      endcase
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    burst_left--;
  endtask

  task automatic send_request(input req_t r, input bit typed,
                              input logic [FINISH_W-1:0] typed_val);
    bit                  has_res;
    logic [FINISH_W-1:0] res;
    pace();
    @(negedge clk);
    in_valid   <= 1'b1;
    func       <= r.f;
    node       <= r.nd;
    duration   <= r.du;
    successor  <= r.sc;
    node_count <= r.cnt;
    do @(posedge clk); while (in_stall);
    apply_request(r, has_res, res);
    if (has_res) exp_project_time.push_back(typed ? typed_val : res);
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (exp_project_time.size() != 0) @(posedge clk);
  endtask

  function automatic logic [DUR_W-1:0] pick_dur();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return DUR_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [NODE_W-1:0] bad_index();
    return $urandom_range(0, 1) ? NODE_W'(0) : NODE_W'($urandom_range(MAX_N + 1, 255));
  endfunction

  function automatic req_t mk_load(input int nd, input logic [DUR_W-1:0] du);
    req_t r;
    r.f   = FUNC_LOAD;
    r.nd  = NODE_W'(nd);
    r.du  = du;
    r.sc  = NODE_W'($urandom_range(0, 255));
    r.cnt = NODE_W'($urandom_range(0, 255));
    return r;
  endfunction

  function automatic req_t mk_edge(input int src, input int dst);
    req_t r;
    r.f   = FUNC_EDGE;
    r.nd  = NODE_W'(src);
    r.du  = DUR_W'($urandom_range(0, 65535));
    r.sc  = NODE_W'(dst);
    r.cnt = NODE_W'($urandom_range(0, 255));
    return r;
  endfunction

  // Shuffles the project, scatters some ignored requests in, closes with a run and sends it.
  task automatic send_plan(input int cnt);
    int   j;
    int   n_noise;
    req_t tmp;
    req_t z;
    for (int i = plan.size() - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      tmp     = plan[i];
      plan[i] = plan[j];
      plan[j] = tmp;
    end
    n_noise = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (n_noise) begin
      z.nd  = NODE_W'($urandom_range(0, 255));
      z.du  = DUR_W'($urandom_range(0, 65535));
      z.sc  = NODE_W'($urandom_range(0, 255));
      z.cnt = NODE_W'($urandom_range(0, 255));
      case ($urandom_range(0, 2))
        0: z.f = FUNC_NONE;
        1: begin
          z.f  = FUNC_LOAD;
          z.nd = bad_index();
        end
        default: begin
          z.f = FUNC_EDGE;
          if ($urandom_range(0, 1)) z.nd = bad_index();
          else z.sc = bad_index();
        end
      endcase
      plan.insert($urandom_range(0, plan.size()), z);
    end
    z     = mk_edge(0, 0);
    z.f   = FUNC_RUN;
    z.nd  = NODE_W'($urandom_range(0, 255));
    z.sc  = NODE_W'($urandom_range(0, 255));
    z.cnt = NODE_W'(cnt);
    plan.push_back(z);
    foreach (plan[i]) send_request(plan[i], 1'b0, '0);
    plan.delete();
  endtask

  task automatic play_chain(input int n, input bit all_max);
    for (int i = 1; i <= n; i++) plan.push_back(mk_load(i, all_max ? '1 : pick_dur()));
    for (int i = 1; i < n; i++) plan.push_back(mk_edge(i, i + 1));
    send_plan(n);
  endtask

  task automatic play_project();
    int kind;
    int n;
    int span;
    int a;
    int b;
    kind = $urandom_range(0, 99);
    if (kind < 4) begin
      // Large project; counts above the node limit are clamped by the block.
      n = $urandom_range(100, 255);
      repeat (10) plan.push_back(mk_load($urandom_range(1, MAX_N), pick_dur()));
      repeat ($urandom_range(50, 200)) begin
        a = $urandom_range(1, MAX_N - 1);
        if ($urandom_range(0, 19) == 0) b = $urandom_range(1, MAX_N);
        else b = a + $urandom_range(1, 6);
        if (b > MAX_N) b = MAX_N;
        plan.push_back(mk_edge(a, b));
      end
      send_plan(n);
    end else if (kind < 12) begin
      play_chain($urandom_range(2, 40), 1'b0);
    end else begin
      // Small project; edges mostly point forward, the rest may form cycles or self loops,
      // and some reach tasks above the run's node count.
      n    = $urandom_range(0, 12);
      span = n + $urandom_range(0, 3);
      if (span == 0) span = 1;
      repeat ($urandom_range(0, span)) plan.push_back(mk_load($urandom_range(1, span), pick_dur()));
      repeat ($urandom_range(0, 2 * span)) begin
        if (span > 1 && $urandom_range(0, 99) < 85) begin
          a = $urandom_range(1, span - 1);
          b = $urandom_range(a + 1, span);
        end else begin
          a = $urandom_range(1, span);
          b = $urandom_range(1, span);
        end
        plan.push_back(mk_edge(a, b));
      end
      send_plan(n);
    end
  endtask

  // Receiver stall pattern: free stretches, random stalls and solid stalls.
  initial begin
    out_stall = 1'b0;
    forever begin
      case ($urandom_range(0, 2))
        0: begin
          repeat ($urandom_range(20, 300)) begin
            @(negedge clk);
            out_stall <= 1'b0;
          end
        end
        1: begin
          repeat ($urandom_range(10, 100)) begin
            @(negedge clk);
            out_stall <= 1'($urandom_range(0, 1));
          end
        end
        default: begin
          repeat ($urandom_range(1, 40)) begin
            @(negedge clk);
            out_stall <= 1'b1;
          end
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (exp_project_time.size() == 0) begin
        $error("project_time: no run pending, actual %0d", project_time);
        err_cnt++;
      end else begin
        want = exp_project_time.pop_front();
        if (project_time !== want) begin
          $error("project_time: expected %0d, actual %0d", want, project_time);
          err_cnt++;
        end
        if (want > longest_seen) longest_seen = want;
        n_results++;
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $error("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
           exp_project_time.size());
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    func         = FUNC_LOAD;
    node         = '0;
    duration     = '0;
    successor    = '0;
    node_count   = '0;
    err_cnt      = 0;
    n_effective  = 0;
    n_ignored    = 0;
    n_runs       = 0;
    n_results    = 0;
    burst_left   = 0;
    longest_seen = '0;

    dir_rows = '{
      '{'{FUNC_RUN,  8'd5,   16'd9,     8'd3,   8'd0},   1'b1, 23'd0},
      '{'{FUNC_NONE, 8'd1,   16'd1234,  8'd2,   8'd2},   1'b0, 23'd0},
      '{'{FUNC_LOAD, 8'd1,   16'hFFFF,  8'd0,   8'd0},   1'b0, 23'd0},
      '{'{FUNC_LOAD, 8'd128, 16'hFFFF,  8'd255, 8'd255}, 1'b0, 23'd0},
      '{'{FUNC_LOAD, 8'd0,   16'd77,    8'd1,   8'd1},   1'b0, 23'd0},
      '{'{FUNC_LOAD, 8'd129, 16'd88,    8'd1,   8'd1},   1'b0, 23'd0},
      '{'{FUNC_LOAD, 8'd255, 16'd99,    8'd1,   8'd1},   1'b0, 23'd0},
      '{'{FUNC_EDGE, 8'd1,   16'd0,     8'd128, 8'd0},   1'b0, 23'd0},
      '{'{FUNC_EDGE, 8'd1,   16'hFFFF,  8'd128, 8'd0},   1'b0, 23'd0},
      '{'{FUNC_EDGE, 8'd0,   16'd0,     8'd1,   8'd0},   1'b0, 23'd0},
      '{'{FUNC_EDGE, 8'd1,   16'd0,     8'd0,   8'd0},   1'b0, 23'd0},
      '{'{FUNC_EDGE, 8'd129, 16'd0,     8'd1,   8'd0},   1'b0, 23'd0},
      '{'{FUNC_EDGE, 8'd1,   16'd0,     8'd255, 8'd0},   1'b0, 23'd0},
      // Edge to a task above the node count is still followed.
      '{'{FUNC_RUN,  8'd0,   16'd0,     8'd0,   8'd1},   1'b1, 23'd131070},
      '{'{FUNC_LOAD, 8'd2,   16'd0,     8'd0,   8'd0},   1'b0, 23'd0},
      '{'{FUNC_LOAD, 8'd3,   16'd10,    8'd0,   8'd0},   1'b0, 23'd0},
      '{'{FUNC_EDGE, 8'd2,   16'd0,     8'd3,   8'd0},   1'b0, 23'd0},
      '{'{FUNC_EDGE, 8'd3,   16'd0,     8'd2,   8'd0},   1'b0, 23'd0},
      // Tasks 2 and 3 form a cycle and never enter the walk.
      '{'{FUNC_RUN,  8'd0,   16'd0,     8'd0,   8'd3},   1'b1, 23'd65535},
      '{'{FUNC_LOAD, 8'd4,   16'd1,     8'd0,   8'd0},   1'b0, 23'd0},
      '{'{FUNC_EDGE, 8'd4,   16'd0,     8'd4,   8'd0},   1'b0, 23'd0},
      '{'{FUNC_EDGE, 8'd2,   16'd0,     8'd3,   8'd0},   1'b0, 23'd0},
      '{'{FUNC_RUN,  8'd0,   16'd0,     8'd0,   8'd4},   1'b0, 23'd0},
      '{'{FUNC_RUN,  8'd0,   16'd0,     8'd0,   8'd2},   1'b0, 23'd0}
    };

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_request(dir_rows[i].r, dir_rows[i].typed, dir_rows[i].val);

    // Every task at the largest duration in one chain gives the longest possible path.
    play_chain(MAX_N, 1'b1);
    wait_all_results();

    while (n_effective < TARGET_REQS) begin
      play_project();
      if ($urandom_range(0, 9) == 0) wait_all_results();
    end

    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d requests plus %0d that the block ignores; %0d projects run.",
             n_effective, n_ignored, n_runs);
    $display("Checked %0d results in %0d cycles; longest path seen %0d.",
             n_results, cycle_cnt, longest_seen);
    if (err_cnt == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
